// File: sv/sfid_pkg.sv
// Package for the smallest-free identifier allocator.
// Holds sizes, the sequencer states, request codes and the find-first-set result type.
// Depends on nothing; every other file of the block imports it.
package sfid_pkg;

  localparam int MAX_ID = 1024;
  localparam int ID_W   = 11;
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROWS   = (MAX_ID + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROWS-1:0]   rowmask_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [BIT_W-1:0]  bitpos_t;

  // Request codes carried by the req_type field.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAKE,
    ST_MARK,
    ST_EMIT
  } state_t;

  // Result of the shared find-first-set unit.
  typedef struct packed {
    logic    found;
    bitpos_t pos;
  } ffs_res_t;

endpackage

// File: sv/smallest_free_id_allocator.sv
// Smallest-free identifier allocator, top level; uses sfid_pkg and sfid_ffs.
// Allocate: a returned identifier goes via SCAN, TAKE, EMIT; a fresh one via SCAN, EMIT.
// Give-back: no result; it marks via accept, row read and row write, or is dropped if out of range.
// A new item is accepted only when idle, once the last is through; the find-first-set unit
// is shared, and a result held by the receiver keeps the block busy until taken.
// Synchronous active-low reset sets the counter to 1, clears row summary and row valid bits.
module smallest_free_id_allocator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_req_type,
  input  sfid_pkg::id_t   in_num,
  output logic            out_valid,
  input  logic            out_stall,
  output sfid_pkg::id_t   out_ident,
  output logic            out_exhausted
);
  import sfid_pkg::*;

  state_t   state_r, state_nxt;
  id_t      next_fresh_r, next_fresh_nxt;
  rowmask_t summary_r, summary_nxt;
  rowmask_t row_valid_r, row_valid_nxt;
  logic     out_valid_r, out_valid_nxt;
  id_t      out_ident_r;
  logic     out_exhausted_r;
  id_t      res_ident_r, res_ident_nxt;
  logic     res_exh_r, res_exh_nxt;
  row_t     row_r, row_nxt;
  bitpos_t  bit_r, bit_nxt;
  logic     req_r;
  id_t      num_r;

  // Bitmap memory and its registered read port.
  word_t    mem [ROWS];
  word_t    rd_data_r;
  logic     rd_vld_r;
  logic     rd_en;
  row_t     rd_row;
  logic     wr_en;
  word_t    wr_word;

  word_t    rd_word;
  word_t    ffs_in;
  ffs_res_t ffs;
  id_t      free_idx;
  logic     free_ok;
  logic     out_load;

  sfid_ffs u_ffs (
    .vec (ffs_in),
    .res (ffs)
  );

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_ident     = out_ident_r;
  assign out_exhausted = out_exhausted_r;

  // A row never written reads as all zeros.
  assign rd_word  = rd_vld_r ? rd_data_r : '0;
  assign ffs_in   = (state_r == ST_SCAN) ? word_t'(summary_r) : rd_word;
  assign free_idx = num_r - id_t'(1);
  assign free_ok  = (num_r != '0) && (num_r < next_fresh_r);
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // Sequencer: next state, memory controls and result staging.
  always_comb begin
    state_nxt      = state_r;
    next_fresh_nxt = next_fresh_r;
    summary_nxt    = summary_r;
    row_valid_nxt  = row_valid_r;
    res_ident_nxt  = res_ident_r;
    res_exh_nxt    = res_exh_r;
    row_nxt        = row_r;
    bit_nxt        = bit_r;
    rd_en          = 1'b0;
    rd_row         = row_r;
    wr_en          = 1'b0;
    wr_word        = rd_word;
    out_valid_nxt  = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (req_r == REQ_FREE) begin
          if (free_ok) begin
            rd_en     = 1'b1;
            rd_row    = free_idx[BIT_W +: ROW_W];
            row_nxt   = free_idx[BIT_W +: ROW_W];
            bit_nxt   = free_idx[BIT_W-1:0];
            state_nxt = ST_MARK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (ffs.found) begin
          rd_en     = 1'b1;
          rd_row    = row_t'(ffs.pos);
          row_nxt   = row_t'(ffs.pos);
          state_nxt = ST_TAKE;
        end else if (next_fresh_r > id_t'(MAX_ID)) begin
          res_ident_nxt = '0;
          res_exh_nxt   = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          res_ident_nxt  = next_fresh_r;
          res_exh_nxt    = 1'b0;
          next_fresh_nxt = next_fresh_r + id_t'(1);
          state_nxt      = ST_EMIT;
        end
      end
      ST_TAKE: begin
        // Clear the lowest marked bit of the row and reissue that identifier.
        wr_en                = 1'b1;
        wr_word              = rd_word & ~(word_t'(1) << ffs.pos);
        row_valid_nxt[row_r] = 1'b1;
        summary_nxt[row_r]   = |wr_word;
        res_ident_nxt        = id_t'({row_r, ffs.pos}) + id_t'(1);
        res_exh_nxt          = 1'b0;
        state_nxt            = ST_EMIT;
      end
      ST_MARK: begin
        // Setting a bit that is already set leaves the row unchanged.
        wr_en                = 1'b1;
        wr_word              = rd_word | (word_t'(1) << bit_r);
        row_valid_nxt[row_r] = 1'b1;
        summary_nxt[row_r]   = 1'b1;
        state_nxt            = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      next_fresh_r <= id_t'(1);
      summary_r    <= '0;
      row_valid_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_fresh_r <= next_fresh_nxt;
      summary_r    <= summary_nxt;
      row_valid_r  <= row_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    res_ident_r <= res_ident_nxt;
    res_exh_r   <= res_exh_nxt;
    row_r       <= row_nxt;
    bit_r       <= bit_nxt;
    if (in_valid && !in_stall) begin
      req_r <= in_req_type;
      num_r <= in_num;
    end
    if (out_load) begin
      out_ident_r     <= res_ident_r;
      out_exhausted_r <= res_exh_r;
    end
  end

  // Bitmap memory: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
      rd_vld_r  <= row_valid_r[rd_row];
    end
    if (wr_en) begin
      mem[row_r] <= wr_word;
    end
  end

  // The counter stays within 1 to MAX_ID + 1.
  a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_fresh_r != '0) && (next_fresh_r <= id_t'(MAX_ID + 1)))
    else $error("identifier counter out of range");

  // A row flagged in the summary must have been written.
  a_summary_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (summary_r & ~row_valid_r) == '0)
    else $error("summary marks a row never written");

  // A row picked from the summary holds at least one marked identifier.
  a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAKE) |-> ffs.found)
    else $error("summary and bitmap row disagree");

  // An exhausted result always carries identifier zero.
  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_exhausted_r) |-> (out_ident_r == '0))
    else $error("exhausted result with non-zero identifier");

  // The counter only moves on the fresh allocate path.
  a_fresh_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |=> $stable(next_fresh_r))
    else $error("identifier counter changed outside a fresh allocate");

endmodule

// File: sv/sfid_ffs.sv
// Shared find-first-set unit of the smallest-free identifier allocator.
// Returns the position of the lowest set bit of one bitmap word.
// Depends on sfid_pkg.
module sfid_ffs (
  input  sfid_pkg::word_t    vec,
  output sfid_pkg::ffs_res_t res
);
  import sfid_pkg::*;

  // Priority encoder: the lowest set bit wins, so scan from the top down.
  always_comb begin
    res.found = |vec;
    res.pos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.pos = bitpos_t'(i);
      end
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for smallest_free_id_allocator: directed and random allocate and give-back items
// checked against an in-bench model of the identifier allocator. Depends on sfid_pkg.
module tb;
  import sfid_pkg::*;

  typedef struct {
    id_t  ident;
    logic exhausted;
  } grant_t;

  logic clk           = 1'b0;
  logic rst_n         = 1'b0;
  logic in_valid      = 1'b0;
  logic in_req_type   = REQ_ALLOC;
  id_t  in_num        = '0;
  logic out_stall     = 1'b0;
  logic in_stall;
  logic out_valid;
  id_t  out_ident;
  logic out_exhausted;

  // Model of the allocator and the grants it still owes.
  int     model_next;
  int     model_marked;
  bit     model_returned [1:MAX_ID];
  grant_t pending_grants [$];
  id_t    held_ids [$];
  id_t    last_given_back = id_t'(1);

  int   mismatches = 0;
  logic steady     = 1'b0;
  int   hold_req   = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;

  smallest_free_id_allocator uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_num       (in_num),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ident    (out_ident),
    .out_exhausted(out_exhausted)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Apply one accepted item to the model and queue the grant it causes.
  task automatic apply_request(input logic req, input id_t num);
    grant_t g;
    int     i;
    bit     hit;
    if (req == REQ_FREE) begin
      if (num >= 1 && num <= MAX_ID && num < model_next && !model_returned[num]) begin
        model_returned[num] = 1'b1;
        model_marked++;
      end
    end else begin
      hit = 1'b0;
      for (i = 1; i < model_next && i <= MAX_ID && !hit; i++) begin
        if (model_returned[i]) begin
          model_returned[i] = 1'b0;
          model_marked--;
          g.ident     = id_t'(i);
          g.exhausted = 1'b0;
          hit         = 1'b1;
        end
      end
      if (!hit) begin
        if (model_next > MAX_ID) begin
          g.ident     = '0;
          g.exhausted = 1'b1;
        end else begin
          g.ident     = id_t'(model_next);
          g.exhausted = 1'b0;
          model_next++;
        end
      end
      pending_grants.push_back(g);
      if (!g.exhausted) held_ids.push_back(g.ident);
    end
  endtask

  // Offer one item, with a random gap first, and wait until it is taken.
  task automatic send_item(input logic req, input id_t num);
    while (!steady && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_num      <= num;
    do @(posedge clk); while (in_stall);
    apply_request(req, num);
    if (req == REQ_FREE) last_given_back = num;
  endtask

  // Choose a give-back number: mostly identifiers in use, the rest odd cases and noise.
  function automatic id_t pick_give_back();
    int  roll;
    int  k;
    id_t v;
    roll = $urandom_range(99);
    if (roll < 60 && held_ids.size() > 0) begin
      k = $urandom_range(held_ids.size() - 1);
      v = held_ids[k];
      held_ids.delete(k);
    end else if (roll < 70) begin
      v = last_given_back;
    end else if (roll < 78) begin
      v = '0;
    end else if (roll < 86) begin
      v = id_t'($urandom_range(2047, (model_next > 2047) ? 2047 : model_next));
    end else begin
      v = id_t'($urandom_range(2047));
    end
    return v;
  endfunction

  task automatic send_random(input int alloc_pct);
    if ($urandom_range(99) < alloc_pct) send_item(REQ_ALLOC, id_t'($urandom));
    else send_item(REQ_FREE, pick_give_back());
  endtask

  // Stop offering items until every owed grant has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0);
  endtask

  task automatic do_reset();
    int i;
    model_next   = 1;
    model_marked = 0;
    for (i = 1; i <= MAX_ID; i++) model_returned[i] = 1'b0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // Fresh identifiers come out in order; the number field is ignored on allocate.
  task automatic test_first_grants();
    send_item(REQ_ALLOC, '0);
    send_item(REQ_ALLOC, id_t'(2047));
    send_item(REQ_ALLOC, id_t'(1024));
    send_item(REQ_ALLOC, id_t'(1365));
  endtask

  // Give-back of zero, of a marked identifier, at or above the counter and past the space.
  task automatic test_give_back_cases();
    send_item(REQ_FREE, '0);
    send_item(REQ_FREE, id_t'(2));
    send_item(REQ_FREE, id_t'(2));
    send_item(REQ_FREE, id_t'(5));
    send_item(REQ_FREE, id_t'(2047));
    send_item(REQ_FREE, id_t'(1024));
    send_item(REQ_FREE, id_t'(1025));
    send_item(REQ_FREE, id_t'(1));
    send_item(REQ_ALLOC, id_t'(682));
    send_item(REQ_ALLOC, '0);
    send_item(REQ_ALLOC, '0);
  endtask

  // The sender pauses until every grant has arrived, then carries on.
  task automatic test_drained_pause();
    send_item(REQ_ALLOC, '0);
    send_item(REQ_FREE, id_t'(3));
    wait_drained();
    send_item(REQ_ALLOC, '0);
    send_item(REQ_ALLOC, '0);
  endtask

  task automatic test_mixed_random();
    int n;
    for (n = 0; n < 100; n++) send_random(65);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_full_backpressure();
    int n;
    hold_req <= hold_req + 1;
    for (n = 0; n < 40; n++) send_random(80);
  endtask

  // Mostly allocate until the space is used up, with a stretch of no idling.
  task automatic test_run_to_exhaustion();
    int n;
    n = 0;
    steady <= 1'b1;
    while (model_next <= MAX_ID) begin
      send_random(97);
      n++;
      if (n == 150) steady <= 1'b0;
    end
    steady <= 1'b0;
    for (n = 0; n < 20; n++) send_random(90);
  endtask

  // Once exhausted: give back the top identifier, reissue it, then run dry again.
  task automatic test_exhausted_edges();
    while (model_marked > 0) send_item(REQ_ALLOC, id_t'($urandom));
    send_item(REQ_FREE, id_t'(MAX_ID));
    send_item(REQ_ALLOC, '0);
    send_item(REQ_ALLOC, '0);
    send_item(REQ_FREE, id_t'(1));
    send_item(REQ_ALLOC, id_t'(2047));
    send_item(REQ_ALLOC, '0);
  endtask

  task automatic test_after_exhaustion();
    int n;
    for (n = 0; n < 50; n++) send_random(55);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 23);
    end
  end

  // Each accepted result is compared with the oldest owed grant.
  always @(posedge clk) begin : check_grants
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result ident=%0d exhausted=%0b",
                                  out_ident, out_exhausted));
      end else begin
        want = pending_grants.pop_front();
        if (out_ident !== want.ident || out_exhausted !== want.exhausted)
          report_mismatch($sformatf("ident=%0d exhausted=%0b, expected %0d %0b",
                                    out_ident, out_exhausted, want.ident, want.exhausted));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    do_reset();
    test_first_grants();
    test_give_back_cases();
    test_drained_pause();
    test_mixed_random();
    test_full_backpressure();
    test_run_to_exhaustion();
    test_exhausted_edges();
    test_after_exhaustion();
    wait_drained();
    repeat (24) @(posedge clk);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
